FILE: rtl/core/sbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI baud divider search package
// Node type, divisor constants and the compare helpers shared by the stages.
// ----------------------------------------------------------------------------
package sbds_pkg;

  localparam int unsigned BusW    = 31;
  localparam int unsigned HzW     = 32;
  localparam int unsigned ProdW   = 65;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned NumDbl  = 2;
  localparam int unsigned NumPre  = 4;
  localparam int unsigned NumScl  = 16;
  localparam int unsigned NumCand = NumDbl * NumPre * NumScl;

  localparam logic [HzW-1:0] NoMatch = 32'hFFFF_FFFF;
  localparam logic [BusW-1:0] BusReset = 31'd50000000;

  // Reciprocal multipliers: floor(n / d) = (n * magic) >> shift for any 32-bit n
  localparam int unsigned NumDiv = 6;
  localparam int unsigned DivBy3  = 0;
  localparam int unsigned DivBy5  = 1;
  localparam int unsigned DivBy7  = 2;
  localparam int unsigned DivBy9  = 3;
  localparam int unsigned DivBy15 = 4;
  localparam int unsigned DivBy21 = 5;

  localparam logic [32:0] DivMagic [NumDiv] = '{
    33'h0_AAAA_AAAB,
    33'h0_CCCC_CCCD,
    33'h1_2492_4925,
    33'h0_E38E_38E4,
    33'h0_8888_8889,
    33'h1_8618_6187
  };
  localparam int unsigned DivShift [NumDiv] = '{33, 34, 35, 35, 35, 37};

  localparam logic [3:0] SclDiv2 = 4'd0;
  localparam logic [3:0] SclDiv4 = 4'd1;
  localparam logic [3:0] SclDiv6 = 4'd2;
  localparam logic [3:0] SclDiv8 = 4'd3;

  typedef struct packed {
    logic [HzW-1:0]  diff;
    logic [BusW-1:0] freq;
    logic [IdxW-1:0] idx;
  } node_t;

  // q = n / prescaler, t = n / (3 * prescaler)
  function automatic logic [HzW-1:0] scaled(input logic [HzW-1:0] q,
                                            input logic [HzW-1:0] t,
                                            input logic [3:0] sel);
    logic [HzW-1:0] f;
    unique case (sel)
      SclDiv2: f = q >> 1;
      SclDiv4: f = q >> 2;
      SclDiv6: f = t >> 1;
      SclDiv8: f = q >> 3;
      default: f = q >> sel;
    endcase
    return f;
  endfunction

  // keep the earlier node unless the later one is strictly closer
  function automatic node_t pick(input node_t a, input node_t b);
    return (b.diff < a.diff) ? b : a;
  endfunction

endpackage

FILE: rtl/core/sbds_quot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI baud divider search, reciprocal products
// Registers the request, the bus clock and its doubled value, then the
// constant reciprocal products for every odd divisor.
// ----------------------------------------------------------------------------
module sbds_quot import sbds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [HzW-1:0]       target_i,
  input  logic [BusW-1:0]      bus_i,
  output logic                 valid_o,
  output logic [HzW-1:0]       target_o,
  output logic [HzW-1:0]       num_o  [NumDbl],
  output logic [ProdW-1:0]     prod_o [NumDbl][NumDiv]
);

  logic               a_valid_q;
  logic [HzW-1:0]     a_target_q;
  logic [HzW-1:0]     a_num_q [NumDbl];
  logic               b_valid_q;
  logic [HzW-1:0]     b_target_q;
  logic [HzW-1:0]     b_num_q [NumDbl];
  logic [ProdW-1:0]   prod_d  [NumDbl][NumDiv];
  logic [ProdW-1:0]   prod_q  [NumDbl][NumDiv];

  always_comb begin
    for (int i = 0; i < NumDbl; i++) begin
      for (int d = 0; d < NumDiv; d++) begin
        prod_d[i][d] = ProdW'(a_num_q[i]) * ProdW'(DivMagic[d]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_target_q <= target_i;
    a_num_q[0] <= {1'b0, bus_i};
    a_num_q[1] <= {bus_i, 1'b0};
    b_target_q <= a_target_q;
    b_num_q    <= a_num_q;
    prod_q     <= prod_d;
  end

  assign valid_o  = b_valid_q;
  assign target_o = b_target_q;
  assign num_o    = b_num_q;
  assign prod_o   = prod_q;

endmodule

FILE: rtl/core/sbds_cand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI baud divider search, candidate stage
// Forms all 128 divider frequencies and their distance to the request.
// ----------------------------------------------------------------------------
module sbds_cand import sbds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [HzW-1:0]   target_i,
  input  logic [HzW-1:0]   num_i  [NumDbl],
  input  logic [ProdW-1:0] prod_i [NumDbl][NumDiv],
  output logic             valid_o,
  output node_t            nodes_o [NumCand]
);

  logic [HzW-1:0] quo [NumDbl][NumDiv];
  node_t          nodes_d [NumCand];
  node_t          nodes_q [NumCand];
  logic           valid_q;

  for (genvar i = 0; i < NumDbl; i++) begin : g_dbl
    for (genvar d = 0; d < NumDiv; d++) begin : g_div
      assign quo[i][d] = HzW'(prod_i[i][d] >> DivShift[d]);
    end
  end

  always_comb begin
    logic [HzW-1:0] q;
    logic [HzW-1:0] t;
    logic [HzW-1:0] f;
    for (int i = 0; i < NumDbl; i++) begin
      for (int p = 0; p < NumPre; p++) begin
        unique case (p)
          0: begin
            q = num_i[i] >> 1;
            t = quo[i][DivBy3] >> 1;
          end
          1: begin
            q = quo[i][DivBy3];
            t = quo[i][DivBy9];
          end
          2: begin
            q = quo[i][DivBy5];
            t = quo[i][DivBy15];
          end
          default: begin
            q = quo[i][DivBy7];
            t = quo[i][DivBy21];
          end
        endcase
        for (int k = 0; k < NumScl; k++) begin
          f = scaled(q, t, 4'(k));
          nodes_d[i*NumPre*NumScl + p*NumScl + k].diff =
              (f > target_i) ? (f - target_i) : (target_i - f);
          nodes_d[i*NumPre*NumScl + p*NumScl + k].freq = f[BusW-1:0];
          nodes_d[i*NumPre*NumScl + p*NumScl + k].idx  = {1'(i), 2'(p), 4'(k)};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nodes_q <= nodes_d;
  end

  assign valid_o = valid_q;
  assign nodes_o = nodes_q;

endmodule

FILE: rtl/core/sbds_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI baud divider search, merge stage
// Two levels of the closest-setting tree: four nodes in, one node out.
// ----------------------------------------------------------------------------
module sbds_merge import sbds_pkg::*; #(
  parameter int unsigned NumIn = 128
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  node_t nodes_i [NumIn],
  output logic  valid_o,
  output node_t nodes_o [NumIn/4]
);

  localparam int unsigned NumOut = NumIn / 4;

  node_t nodes_d [NumOut];
  node_t nodes_q [NumOut];
  logic  valid_q;

  always_comb begin
    for (int n = 0; n < NumOut; n++) begin
      nodes_d[n] = pick(pick(nodes_i[4*n], nodes_i[4*n+1]),
                        pick(nodes_i[4*n+2], nodes_i[4*n+3]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nodes_q <= nodes_d;
  end

  assign valid_o = valid_q;
  assign nodes_o = nodes_q;

endmodule

FILE: rtl/core/spi_baud_divider_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI baud divider search
// Picks the doubler, prescaler and scaler setting closest to a requested
// SPI clock.
// ----------------------------------------------------------------------------
// busy stays low: a new request word is taken in every cycle that start is
// high. Its result shows on the result ports with done_o for one cycle,
// in request order; the receiver cannot stall it. Each request passes
// through the input register, the reciprocal product register, the
// candidate stage, three 4:1 compare stages and the output register.
// cfg_ready_o is always high; write the bus clock only while no request
// is in flight.
// ----------------------------------------------------------------------------
module spi_baud_divider_search_top import sbds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [31:0]     target_hz_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [30:0]     cfg_data_i,
  output logic            done_o,
  output logic            double_rate_o,
  output logic [1:0]      prescale_sel_o,
  output logic [3:0]      scale_sel_o,
  output logic [30:0]     achieved_hz_o,
  output logic            found_o
);

  logic [BusW-1:0]  bus_q;
  logic             quot_valid;
  logic [HzW-1:0]   quot_target;
  logic [HzW-1:0]   quot_num  [NumDbl];
  logic [ProdW-1:0] quot_prod [NumDbl][NumDiv];
  logic             cand_valid;
  node_t            cand_nodes [NumCand];
  logic             m1_valid;
  node_t            m1_nodes [NumCand/4];
  logic             m2_valid;
  node_t            m2_nodes [NumCand/16];
  logic             m3_valid;
  node_t            m3_nodes [NumCand/64];
  node_t            best;
  logic             found;
  logic             done_q;
  logic             found_q;
  logic [IdxW-1:0]  idx_q;
  logic [BusW-1:0]  hz_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= BusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bus_q <= cfg_data_i;
    end
  end

  sbds_quot u_quot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .target_i (target_hz_i),
    .bus_i    (bus_q),
    .valid_o  (quot_valid),
    .target_o (quot_target),
    .num_o    (quot_num),
    .prod_o   (quot_prod)
  );

  sbds_cand u_cand (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (quot_valid),
    .target_i (quot_target),
    .num_i    (quot_num),
    .prod_i   (quot_prod),
    .valid_o  (cand_valid),
    .nodes_o  (cand_nodes)
  );

  sbds_merge #(.NumIn(NumCand)) u_merge1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cand_valid),
    .nodes_i (cand_nodes),
    .valid_o (m1_valid),
    .nodes_o (m1_nodes)
  );

  sbds_merge #(.NumIn(NumCand/4)) u_merge2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m1_valid),
    .nodes_i (m1_nodes),
    .valid_o (m2_valid),
    .nodes_o (m2_nodes)
  );

  sbds_merge #(.NumIn(NumCand/16)) u_merge3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m2_valid),
    .nodes_i (m2_nodes),
    .valid_o (m3_valid),
    .nodes_o (m3_nodes)
  );

  assign best  = pick(m3_nodes[0], m3_nodes[1]);
  assign found = (best.diff != NoMatch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found;
    idx_q   <= found ? best.idx : '0;
    hz_q    <= found ? best.freq : '0;
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign double_rate_o  = idx_q[6];
  assign prescale_sel_o = idx_q[5:4];
  assign scale_sel_o    = idx_q[3:0];
  assign achieved_hz_o  = hz_q;

endmodule
